/* rtl/packed_rgb_strip_unpacker_unit_defines.svh */
// Assertion macros for the packed RGB strip unpacker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PACKED_RGB_STRIP_UNPACKER_UNIT_DEFINES_SVH
`define PACKED_RGB_STRIP_UNPACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("prsu check failed");

// Next-cycle implication, disabled during reset.
`define PRSU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("prsu check failed");

`endif

/* rtl/prsu_pkg.sv */
// Shared types and constants of the packed RGB strip unpacker.
// No dependencies; imported by every module of the block.
package prsu_pkg;

    // Group geometry
    localparam int GROUP_BYTES = 12;
    localparam int HELD_N      = GROUP_BYTES - 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_SPP   = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    // Sample width codes (anything else acts as 16 bits)
    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_12 = 2'd1;

    // Samples per pixel codes; anything but RGBA acts as RGB
    localparam logic [2:0] SPP_RGB  = 3'd3;
    localparam logic [2:0] SPP_RGBA = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  spp;
        logic [23:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
        logic        run_last;
        logic        image_done;
    } t_pixel;

    // Results of one processed item toward the result queue
    typedef struct packed {
        logic [1:0] num;
        t_pixel     pix0;
        t_pixel     pix1;
    } t_push;

endpackage

/* rtl/prsu_cfg.sv */
// Configuration register file of the packed RGB strip unpacker.
// Depends on prsu_pkg.
module prsu_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [23:0]    i_cfg_data,
    output prsu_pkg::t_cfg o_cfg
);
    import prsu_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_8;
            r_cfg.spp   <= SPP_RGB;
            r_cfg.limit <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[1:0];
                CFG_SPP:   r_cfg.spp   <= i_cfg_data[2:0];
                CFG_LIMIT: r_cfg.limit <= i_cfg_data;
                default:   ;
            endcase
        end
    end

endmodule

/* rtl/prsu_core.sv */
// Input register, group assembly and pixel formatting of the strip unpacker.
// Depends on prsu_pkg and the assertion macro header.
module prsu_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prsu_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_strip_end,
    input  logic            i_space,
    output prsu_pkg::t_push o_push
);
    import prsu_pkg::*;
    `include "packed_rgb_strip_unpacker_unit_defines.svh"

    function automatic logic [11:0] hi12(input logic [7:0] a, input logic [7:0] b);
        return {a, b[7:4]};
    endfunction

    function automatic logic [11:0] lo12(input logic [7:0] a, input logic [7:0] b);
        return {a[3:0], b};
    endfunction

    function automatic logic [11:0] le16(input logic [7:0] lo, input logic [7:0] hi);
        return {hi, lo[7:4]};
    endfunction

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;

    // Group state
    logic [3:0]  r_pos;
    logic [7:0]  r_held [HELD_N];
    logic [23:0] r_cnt;

    logic        fire;
    logic        is8, is12, rgba;
    logic [3:0]  len;
    logic [3:0]  pos;
    logic        complete;
    logic [7:0]  g [GROUP_BYTES];
    logic        fit;
    logic [23:0] cnt1, cnt2;
    logic        done0, done1;
    t_push       push;
    logic [3:0]  n_pos;
    logic [23:0] n_cnt;

    assign fire    = r_in_valid && i_space;
    assign o_stall = r_in_valid && !i_space;

    // Group layout from the current configuration
    always_comb begin
        is8  = (i_cfg.mode == MODE_8);
        is12 = (i_cfg.mode == MODE_12);
        rgba = (i_cfg.spp == SPP_RGBA);
        if (is8)       len = rgba ? 4'd4 : 4'd3;
        else if (is12) len = rgba ? 4'd12 : 4'd9;
        else           len = rgba ? 4'd8 : 4'd6;
        pos      = (r_pos > 4'(HELD_N)) ? 4'(HELD_N) : r_pos;
        complete = ({1'b0, pos} + 5'd1) >= {1'b0, len};
    end

    // Group bytes: held bytes with the current byte dropped in at its place
    always_comb begin
        for (int i = 0; i < HELD_N; i++) begin
            g[i] = r_held[i];
        end
        g[GROUP_BYTES-1] = 8'h00;
        g[pos] = r_byte;
    end

    // Pixel formatting and limit check
    always_comb begin
        cnt1  = r_cnt + 24'd1;
        cnt2  = r_cnt + 24'd2;
        done0 = (cnt1 == i_cfg.limit);
        done1 = (cnt2 == i_cfg.limit);
        fit   = is12 ? (({1'b0, r_cnt} + 25'd1) < {1'b0, i_cfg.limit})
                     : (r_cnt < i_cfg.limit);
        push  = '0;
        if (is8) begin
            push.pix0.red   = {g[0], 4'h0};
            push.pix0.green = {g[1], 4'h0};
            push.pix0.blue  = {g[2], 4'h0};
            push.pix0.run_last = 1'b1;
        end else if (is12) begin
            push.pix0.red   = hi12(g[0], g[1]);
            push.pix0.green = lo12(g[1], g[2]);
            push.pix0.blue  = hi12(g[3], g[4]);
            if (rgba) begin
                push.pix1.red   = hi12(g[6], g[7]);
                push.pix1.green = lo12(g[7], g[8]);
                push.pix1.blue  = hi12(g[9], g[10]);
            end else begin
                push.pix1.red   = lo12(g[4], g[5]);
                push.pix1.green = hi12(g[6], g[7]);
                push.pix1.blue  = lo12(g[7], g[8]);
            end
            push.pix1.run_last   = 1'b1;
            push.pix1.image_done = done1;
        end else begin
            push.pix0.red   = le16(g[0], g[1]);
            push.pix0.green = le16(g[2], g[3]);
            push.pix0.blue  = le16(g[4], g[5]);
            push.pix0.run_last = 1'b1;
        end
        push.pix0.image_done = done0;
        if (fire && complete && fit) push.num = is12 ? 2'd2 : 2'd1;
    end

    assign o_push = push;

    // Next group position and pixel count
    always_comb begin
        n_pos = r_pos;
        n_cnt = r_cnt;
        if (fire) begin
            if (complete) n_pos = '0;
            else          n_pos = r_end ? 4'd0 : pos + 4'd1;
            if (push.num == 2'd2)      n_cnt = cnt2;
            else if (push.num == 2'd1) n_cnt = cnt1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_cnt      <= '0;
        end else begin
            if (!o_stall) r_in_valid <= i_valid;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_byte <= i_data_byte;
            r_end  <= i_strip_end;
        end
        if (fire && !complete) r_held[pos] <= r_byte;
    end

    `PRSU_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= 4'(HELD_N))
    `PRSU_ASSERT_NXT(a_group_restart, i_clk, i_rst_n, fire && complete, r_pos == 4'd0)
    `PRSU_ASSERT_IMP(a_push_only_on_fire, i_clk, i_rst_n, push.num != 2'd0, fire && complete)

endmodule

/* rtl/prsu_fifo.sv */
// Result queue of the strip unpacker: takes up to two pixels a cycle.
// Depends on prsu_pkg and the assertion macro header.
module prsu_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prsu_pkg::t_push i_push,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_stall,
    output prsu_pkg::t_pixel o_pixel
);
    import prsu_pkg::*;
    `include "packed_rgb_strip_unpacker_unit_defines.svh"

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_pixel          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_count;
    logic            pop;
    logic [AW-1:0]   wp1;

    assign o_valid = (r_count != '0);
    assign o_pixel = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    // Room for a full pair, judged from registered fill only
    assign o_space = (r_count <= (AW+1)'(DEPTH - 2));
    assign wp1     = r_wp + AW'(1);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + AW'(i_push.num);
            if (pop) r_rp <= r_rp + AW'(1);
            r_count <= r_count + (AW+1)'(i_push.num) - (AW+1)'(pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_mem[r_wp] <= i_push.pix0;
        if (i_push.num == 2'd2) r_mem[wp1]  <= i_push.pix1;
    end

    `PRSU_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_count <= (AW+1)'(DEPTH))
    `PRSU_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.num != 2'd0, o_space)
    `PRSU_ASSERT_NXT(a_pop_drains, i_clk, i_rst_n, pop && (i_push.num == 2'd0), r_count == $past(r_count) - (AW+1)'(1))

endmodule

/* rtl/packed_rgb_strip_unpacker_unit.sv */
// Packed RGB strip unpacker: one raw strip byte per item in, 12-bit RGB pixels out.
// Takes a byte in every cycle unless stalled; each byte is registered, then assembled into
// its sample group and, when it completes the group, formatted into one pixel (8- and
// 16-bit samples) or two pixels (12-bit packed pairs) that enter a four-entry result
// queue in the same step. The sustained rate is one byte per cycle while the queue has
// room, set by the combinational path from the input register through group assembly
// into the queue; the byte input stalls only when the queue holds more than two pixels.
// The first pixel a byte causes passes through the input register and then the result
// queue on its way to the output; the second pixel of a pair follows it out of the queue.
// Configuration writes are always ready and are registered before they take effect;
// write them only while no item is in flight.
// Depends on prsu_pkg, prsu_cfg, prsu_core and prsu_fifo.
module packed_rgb_strip_unpacker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_strip_end,
    // Pixel output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_red,
    output logic [11:0] o_green,
    output logic [11:0] o_blue,
    output logic        o_run_last,
    output logic        o_image_done,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import prsu_pkg::*;

    t_cfg   cfg;
    t_push  push;
    t_pixel pixel;
    logic   space;

    prsu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prsu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_strip_end (i_strip_end),
        .i_space     (space),
        .o_push      (push)
    );

    prsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (pixel)
    );

    assign o_red        = pixel.red;
    assign o_green      = pixel.green;
    assign o_blue       = pixel.blue;
    assign o_run_last   = pixel.run_last;
    assign o_image_done = pixel.image_done;

endmodule
